@@ rtl/qte_pkg.sv @@
// Shared widths, constants, types and arctangent table of the quaternion to Euler block.
`default_nettype none
package qte_pkg;

  localparam int IN_W       = 32;
  localparam int PROD_W     = 64;
  localparam int OP_W       = 64;
  localparam int NORM_BITS  = 40;
  localparam int CX_W       = 44;
  localparam int ACC_W      = 34;
  localparam int SQ_W       = 62;
  localparam int SQRT_CELLS = 31;
  localparam int K_W        = 5;
  localparam int MARGIN_W   = 30;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 30'd107374;

  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [35:0] LIM_FIRST  = 36'sd1686629713;
  localparam logic signed [35:0] LIM_SECOND = 36'sd421657428;
  localparam logic signed [35:0] LIM_THIRD  = 36'sd843314857;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_POS  = 2'd1,
    LOCK_NEG  = 2'd2
  } lock_e;

  // One square root cell's working remainder and partial root.
  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  // One vectoring rotation's working vector and angle.
  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } cordic_t;

endpackage
`default_nettype wire

@@ rtl/qte_sqrt_cell.sv @@
// One root bit of the pipelined floor square root.
`default_nettype none
module qte_sqrt_cell #(
  parameter int J = 0
) (
  input  wire                 clk_i,
  input  qte_pkg::sqrt_t      sq_i,
  output qte_pkg::sqrt_t      sq_o
);

  localparam logic [qte_pkg::SQ_W-1:0] BIT = qte_pkg::SQ_W'(1) << (2 * J);

  qte_pkg::sqrt_t sq_d, sq_q;
  logic [qte_pkg::SQ_W-1:0] trial;

  always_comb begin
    trial = sq_i.r + BIT;
    if (sq_i.v >= trial) begin
      sq_d.v = sq_i.v - trial;
      sq_d.r = (sq_i.r >> 1) + BIT;
    end else begin
      sq_d.v = sq_i.v;
      sq_d.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

@@ rtl/qte_norm.sv @@
// Operand scaling and quarter-turn pre-rotation ahead of a vectoring chain.
`default_nettype none
module qte_norm (
  input  wire                              clk_i,
  input  wire signed [qte_pkg::OP_W-1:0]   y_i,
  input  wire signed [qte_pkg::OP_W-1:0]   x_i,
  output qte_pkg::cordic_t                 cd_o
);

  logic [qte_pkg::OP_W-1:0] ax, ay, m;
  logic [qte_pkg::K_W-1:0]  k_d, k_q;
  logic signed [qte_pkg::OP_W-1:0] y_q, x_q, ys, xs;
  logic zero_q;
  qte_pkg::cordic_t cd_d, cd_q;

  // Shift count that brings the larger magnitude below the working limit.
  always_comb begin
    ax  = x_i[qte_pkg::OP_W-1] ? (~x_i + 1'b1) : x_i;
    ay  = y_i[qte_pkg::OP_W-1] ? (~y_i + 1'b1) : y_i;
    m   = (ax > ay) ? ax : ay;
    k_d = '0;
    for (int b = qte_pkg::NORM_BITS; b < qte_pkg::OP_W; b++) begin
      if (m[b]) k_d = qte_pkg::K_W'(b - qte_pkg::NORM_BITS + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_i;
    x_q    <= x_i;
    k_q    <= k_d;
    zero_q <= (x_i == '0) && (y_i == '0);
  end

  always_comb begin
    xs      = x_q >>> k_q;
    ys      = y_q >>> k_q;
    cd_d.zero = zero_q;
    if (xs[qte_pkg::OP_W-1]) begin
      if (!ys[qte_pkg::OP_W-1]) begin
        cd_d.x   = qte_pkg::CX_W'(ys);
        cd_d.y   = qte_pkg::CX_W'(-xs);
        cd_d.acc = qte_pkg::HALF_PI_Q30;
      end else begin
        cd_d.x   = qte_pkg::CX_W'(-ys);
        cd_d.y   = qte_pkg::CX_W'(xs);
        cd_d.acc = -qte_pkg::HALF_PI_Q30;
      end
    end else begin
      cd_d.x   = qte_pkg::CX_W'(xs);
      cd_d.y   = qte_pkg::CX_W'(ys);
      cd_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cd_q <= cd_d;
  end

  assign cd_o = cd_q;

endmodule
`default_nettype wire

@@ rtl/qte_cordic_cell.sv @@
// One vectoring rotation of the arctangent chain.
`default_nettype none
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire                 clk_i,
  input  qte_pkg::cordic_t    cd_i,
  output qte_pkg::cordic_t    cd_o
);

  localparam logic signed [qte_pkg::ACC_W-1:0] ATAN =
    $signed({{(qte_pkg::ACC_W-30){1'b0}}, qte_pkg::ATAN_Q30[STEP]});

  qte_pkg::cordic_t cd_d, cd_q;
  logic signed [qte_pkg::CX_W-1:0] dx, dy;

  always_comb begin
    dx = cd_i.y >>> STEP;
    dy = cd_i.x >>> STEP;
    cd_d.zero = cd_i.zero;
    if (cd_i.y > 0) begin
      cd_d.x   = cd_i.x + dx;
      cd_d.y   = cd_i.y - dy;
      cd_d.acc = cd_i.acc + ATAN;
    end else begin
      cd_d.x   = cd_i.x - dx;
      cd_d.y   = cd_i.y + dy;
      cd_d.acc = cd_i.acc - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    cd_q <= cd_d;
  end

  assign cd_o = cd_q;

endmodule
`default_nettype wire

@@ rtl/quaternion_to_euler_angles.sv @@
// Top level of the quaternion to Euler angle converter with gimbal lock detection.
//
// Usage: drive the four Q2.30 quaternion components on quat_*_i and raise start
// for one cycle per word. busy is always low, so a word is taken at every rising
// edge where start is high; one word may follow another in every cycle.
// Each word yields exactly one result word: first, second and third angle in
// radians as Q3.28, Q1.28 and Q2.28, plus the lock state. The result is shown
// for one cycle with done_o high. A word passes through the input register,
// the product stage, the stage of the lock test and sums, the squaring stage,
// the 31 root cells of the square root that feeds the arcsine, the two operand
// scaling stages, one chain of CORDIC_STEPS rotation cells for each of the
// three angles, and the output register.
// The receiver cannot stall, so no result is ever held back.
// Reset clears the pipeline valid bits and loads the lock margin register with
// its default of about 0.0001; a write with cfg_we_i loads a new margin and
// should be done while no word is in flight.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire signed [qte_pkg::IN_W-1:0]     quat_w_i,
  input  wire signed [qte_pkg::IN_W-1:0]     quat_x_i,
  input  wire signed [qte_pkg::IN_W-1:0]     quat_y_i,
  input  wire signed [qte_pkg::IN_W-1:0]     quat_z_i,
  input  wire                                cfg_we_i,
  input  wire [qte_pkg::MARGIN_W-1:0]        cfg_data_i,
  output logic                               done_o,
  output logic signed [31:0]                 first_angle_o,
  output logic signed [29:0]                 second_angle_o,
  output logic signed [30:0]                 third_angle_o,
  output logic [1:0]                         lock_state_o
);

  localparam int LAT      = 38 + CORDIC_STEPS;
  localparam int LOCK_DLY = 34 + CORDIC_STEPS;
  localparam int OP_W     = qte_pkg::OP_W;
  localparam int ACC_W    = qte_pkg::ACC_W;

  // Operands that wait beside the square root.
  typedef struct packed {
    logic signed [OP_W-1:0] y1;
    logic signed [OP_W-1:0] x1;
    logic signed [OP_W-1:0] y3;
    logic signed [OP_W-1:0] x3;
    logic signed [31:0]     s;
  } side_t;

  // The block never refuses a word.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  logic [qte_pkg::MARGIN_W-1:0] margin_q;
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= qte_pkg::MARGIN_RESET;
      vld_q    <= '0;
    end else begin
      if (cfg_we_i) margin_q <= cfg_data_i;
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // Input capture.
  logic signed [31:0] w_q, x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    w_q <= quat_w_i;
    x_q <= quat_x_i;
    y_q <= quat_y_i;
    z_q <= quat_z_i;
  end

  // All nine products in parallel, one multiplier per register.
  logic signed [63:0] p_xz_q, p_wy_q, p_yy_q, p_zz_q, p_ww_q;
  logic signed [63:0] p_xw_q, p_yz_q, p_xy_q, p_zw_q;
  logic signed [31:0] w2_q, y2_q;
  always_ff @(posedge clk_i) begin
    p_xz_q <= x_q * z_q;
    p_wy_q <= w_q * y_q;
    p_yy_q <= y_q * y_q;
    p_zz_q <= z_q * z_q;
    p_ww_q <= w_q * w_q;
    p_xw_q <= x_q * w_q;
    p_yz_q <= y_q * z_q;
    p_xy_q <= x_q * y_q;
    p_zw_q <= z_q * w_q;
    w2_q   <= w_q;
    y2_q   <= y_q;
  end

  // Lock test and the sums of the normal branch.
  logic signed [64:0] test, thr, s_full;
  logic signed [63:0] num1, den1, num3, den3;
  logic signed [31:0] s_d;
  qte_pkg::lock_e lock_d;
  side_t side_d;

  always_comb begin
    test = 65'(p_xz_q) - 65'(p_wy_q);
    thr  = (65'sd1 <<< 59) - $signed({5'd0, margin_q, 30'd0});
    if (test > thr) begin
      lock_d = qte_pkg::LOCK_POS;
    end else if (test < -thr) begin
      lock_d = qte_pkg::LOCK_NEG;
    end else begin
      lock_d = qte_pkg::LOCK_NONE;
    end
    num1 = ((p_xw_q >>> 2) + (p_yz_q >>> 2)) <<< 1;
    den1 = (64'sd1 <<< 58) - (((p_zz_q >>> 2) + (p_ww_q >>> 2)) <<< 1);
    num3 = ((p_xy_q >>> 2) - (p_zw_q >>> 2)) <<< 1;
    den3 = (64'sd1 <<< 58) - (((p_yy_q >>> 2) + (p_zz_q >>> 2)) <<< 1);
    s_full = test >>> 29;
    if (s_full > (65'sd1 <<< 30)) begin
      s_d = 32'sd1073741824;
    end else if (s_full < -(65'sd1 <<< 30)) begin
      s_d = -32'sd1073741824;
    end else begin
      s_d = 32'(s_full);
    end
    // In lock the first angle is taken from y and w directly.
    if (lock_d != qte_pkg::LOCK_NONE) begin
      side_d.y1 = OP_W'(y2_q);
      side_d.x1 = OP_W'(w2_q);
    end else begin
      side_d.y1 = num1;
      side_d.x1 = den1;
    end
    side_d.y3 = num3;
    side_d.x3 = den3;
    side_d.s  = s_d;
  end

  side_t side_c_q;
  qte_pkg::lock_e lock_q [LOCK_DLY+1];
  always_ff @(posedge clk_i) begin
    side_c_q  <= side_d;
    lock_q[0] <= lock_d;
    for (int i = 0; i < LOCK_DLY; i++) begin
      lock_q[i+1] <= lock_q[i];
    end
  end

  // Radicand of the arcsine cosine.
  qte_pkg::sqrt_t sq [qte_pkg::SQRT_CELLS+1];
  qte_pkg::sqrt_t sq0_q;
  side_t side_q [qte_pkg::SQRT_CELLS+1];
  logic signed [63:0] ss;
  always_comb begin
    ss = side_c_q.s * side_c_q.s;
  end
  always_ff @(posedge clk_i) begin
    sq0_q.v   <= qte_pkg::SQ_W'((64'sd1 <<< 60) - ss);
    sq0_q.r   <= '0;
    side_q[0] <= side_c_q;
    for (int i = 0; i < qte_pkg::SQRT_CELLS; i++) begin
      side_q[i+1] <= side_q[i];
    end
  end
  assign sq[0] = sq0_q;

  for (genvar g = 0; g < qte_pkg::SQRT_CELLS; g++) begin : g_sqrt
    qte_sqrt_cell #(.J(qte_pkg::SQRT_CELLS - 1 - g)) u_cell (
      .clk_i (clk_i),
      .sq_i  (sq[g]),
      .sq_o  (sq[g+1])
    );
  end

  side_t side_e;
  logic signed [OP_W-1:0] y2_op, x2_op;
  assign side_e = side_q[qte_pkg::SQRT_CELLS];
  assign y2_op  = OP_W'(side_e.s);
  assign x2_op  = $signed({33'd0, sq[qte_pkg::SQRT_CELLS].r[30:0]});

  qte_pkg::cordic_t cd1 [CORDIC_STEPS+1];
  qte_pkg::cordic_t cd2 [CORDIC_STEPS+1];
  qte_pkg::cordic_t cd3 [CORDIC_STEPS+1];

  qte_norm u_norm1 (.clk_i(clk_i), .y_i(side_e.y1), .x_i(side_e.x1), .cd_o(cd1[0]));
  qte_norm u_norm2 (.clk_i(clk_i), .y_i(y2_op),     .x_i(x2_op),     .cd_o(cd2[0]));
  qte_norm u_norm3 (.clk_i(clk_i), .y_i(side_e.y3), .x_i(side_e.x3), .cd_o(cd3[0]));

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    qte_cordic_cell #(.STEP(g)) u_c1 (.clk_i(clk_i), .cd_i(cd1[g]), .cd_o(cd1[g+1]));
    qte_cordic_cell #(.STEP(g)) u_c2 (.clk_i(clk_i), .cd_i(cd2[g]), .cd_o(cd2[g+1]));
    qte_cordic_cell #(.STEP(g)) u_c3 (.clk_i(clk_i), .cd_i(cd3[g]), .cd_o(cd3[g+1]));
  end

  // Both operands zero give an angle of zero.
  function automatic logic signed [ACC_W-1:0] angle(input qte_pkg::cordic_t c);
    return c.zero ? '0 : c.acc;
  endfunction

  function automatic logic signed [35:0] to_q28(input logic signed [ACC_W-1:0] a);
    logic signed [35:0] t;
    t = 36'(a) + 36'sd2;
    return t >>> 2;
  endfunction

  function automatic logic signed [35:0] half_up(input logic signed [ACC_W-1:0] a);
    logic signed [35:0] t;
    t = 36'(a) + 36'sd1;
    return t >>> 1;
  endfunction

  function automatic logic signed [35:0] clamp(input logic signed [35:0] v,
                                               input logic signed [35:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  qte_pkg::lock_e lock_e_w;
  logic signed [ACC_W-1:0] a1, a2, a3;
  logic signed [35:0] f_d, s2_d, t_d;
  assign lock_e_w = lock_q[LOCK_DLY];
  assign a1 = angle(cd1[CORDIC_STEPS]);
  assign a2 = angle(cd2[CORDIC_STEPS]);
  assign a3 = angle(cd3[CORDIC_STEPS]);

  always_comb begin
    unique case (lock_e_w)
      qte_pkg::LOCK_POS: begin
        f_d  = half_up(a1);
        s2_d = qte_pkg::LIM_SECOND;
        t_d  = '0;
      end
      qte_pkg::LOCK_NEG: begin
        f_d  = -half_up(a1);
        s2_d = -qte_pkg::LIM_SECOND;
        t_d  = '0;
      end
      default: begin
        f_d  = to_q28(a1);
        s2_d = to_q28(a2);
        t_d  = to_q28(a3);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    first_angle_o  <= 32'(clamp(f_d, qte_pkg::LIM_FIRST));
    second_angle_o <= 30'(clamp(s2_d, qte_pkg::LIM_SECOND));
    third_angle_o  <= 31'(clamp(t_d, qte_pkg::LIM_THIRD));
    lock_state_o   <= lock_e_w;
  end

  assign done_o = vld_q[LAT-1];

`ifndef SYNTH
  // A locked result always has a zero third angle.
  a_lock_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (lock_state_o != qte_pkg::LOCK_NONE) |-> third_angle_o == '0)
    else $error("third angle not zero under gimbal lock");

  // Positive lock pins the second angle at plus a quarter turn.
  a_lock_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (lock_state_o == qte_pkg::LOCK_POS) |->
      second_angle_o == 30'(qte_pkg::LIM_SECOND))
    else $error("second angle wrong under positive lock");

  // A result leaves exactly one pipeline length after its word was taken.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(LAT-1) done_o)
    else $error("result strobe missing at the pipeline end");
`endif

endmodule
`default_nettype wire

@@ sim/quaternion_to_euler_angles_tb.sv @@
// Self-checking testbench of the quaternion to Euler angle converter.
`timescale 1ns / 100ps
`default_nettype none
module quaternion_to_euler_angles_tb;

  // Wide signed working type: the lock test x*z - w*y needs more than 64 bits
  // to stay exact at the extremes of the Q2.30 inputs.
  typedef logic signed [71:0] wide_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] first;
    logic signed [29:0] second;
    logic signed [30:0] third;
    logic [1:0]         lock;
  } angles_t;

  localparam int LATENCY    = 38 + qte_pkg::CORDIC_STEPS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int A_UNIT     = 759250125;  // about 2^30 / sqrt(2)

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [qte_pkg::MARGIN_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] first_angle_o;
  logic signed [29:0] second_angle_o;
  logic signed [30:0] third_angle_o;
  logic [1:0] lock_state_o;

  quaternion_to_euler_angles dut (
    .clk_i, .rst_ni, .start, .busy,
    .quat_w_i, .quat_x_i, .quat_y_i, .quat_z_i,
    .cfg_we_i, .cfg_data_i,
    .done_o, .first_angle_o, .second_angle_o, .third_angle_o, .lock_state_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Words waiting to be sent, and the angle words predicted for accepted ones.
  quat_t   quat_queue[$];
  angles_t angle_queue[$];
  logic [qte_pkg::MARGIN_W-1:0] margin_model = qte_pkg::MARGIN_RESET;
  int idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Floor integer square root of a 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC arctangent of y/x, angle at 30 fraction bits.
  function automatic wide_t atan2_q30(wide_t y, wide_t x);
    wide_t ax, ay, m, acc, t, dx, dy;
    int k;
    if (x == 0 && y == 0) return 0;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    k = 0;
    while (m >= (wide_t'(1) <<< 40)) begin
      m = m >>> 1;
      k++;
    end
    x = x >>> k;
    y = y >>> k;
    acc = 0;
    // A quarter turn brings a left half-plane vector into the right half.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = qte_pkg::HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; acc = -qte_pkg::HALF_PI_Q30;
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; acc += wide_t'(qte_pkg::ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; acc -= wide_t'(qte_pkg::ATAN_Q30[i]);
      end
    end
    return acc;
  endfunction

  function automatic wide_t clip(wide_t v, wide_t lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic wide_t q30_to_q28(wide_t a);
    return (a + 2) >>> 2;
  endfunction

  // Predicts the angle word of one quaternion under the given margin.
  function automatic angles_t euler_of(quat_t q, logic [qte_pkg::MARGIN_W-1:0] margin);
    wide_t w, x, y, z, test, thr, f, s2, t3, yy, zz, ww, n1, d1, n3, d3, sn, cs;
    angles_t r;
    qte_pkg::lock_e st;
    w = q.w; x = q.x; y = q.y; z = q.z;
    test = x * z - w * y;
    thr = (wide_t'(1) <<< 59) - (wide_t'(margin) <<< 30);
    if (test > thr) begin
      f = (atan2_q30(y, w) + 1) >>> 1;
      s2 = qte_pkg::LIM_SECOND;
      t3 = 0;
      st = qte_pkg::LOCK_POS;
    end else if (test < -thr) begin
      f = -((atan2_q30(y, w) + 1) >>> 1);
      s2 = -qte_pkg::LIM_SECOND;
      t3 = 0;
      st = qte_pkg::LOCK_NEG;
    end else begin
      yy = (y * y) >>> 2;
      zz = (z * z) >>> 2;
      ww = (w * w) >>> 2;
      n1 = 2 * (((x * w) >>> 2) + ((y * z) >>> 2));
      d1 = (wide_t'(1) <<< 58) - 2 * (zz + ww);
      n3 = 2 * (((x * y) >>> 2) - ((z * w) >>> 2));
      d3 = (wide_t'(1) <<< 58) - 2 * (yy + zz);
      sn = clip(test >>> 29, wide_t'(1) <<< 30);
      cs = wide_t'(root_floor(64'(longint'(1) << 60) - 64'(sn * sn)));
      f  = q30_to_q28(atan2_q30(n1, d1));
      s2 = q30_to_q28(atan2_q30(sn, cs));
      t3 = q30_to_q28(atan2_q30(n3, d3));
      st = qte_pkg::LOCK_NONE;
    end
    r.first  = 32'(clip(f, qte_pkg::LIM_FIRST));
    r.second = 30'(clip(s2, qte_pkg::LIM_SECOND));
    r.third  = 31'(clip(t3, qte_pkg::LIM_THIRD));
    r.lock   = st;
    return r;
  endfunction

  // Driver: one word per cycle at most, with random idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!start || !busy) begin
        if (quat_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          quat_w_i <= quat_queue[0].w;
          quat_x_i <= quat_queue[0].x;
          quat_y_i <= quat_queue[0].y;
          quat_z_i <= quat_queue[0].z;
          void'(quat_queue.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts at acceptance, checks each strobed result word.
  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        angle_queue.push_back(euler_of({quat_w_i, quat_x_i, quat_y_i, quat_z_i},
                                       margin_model));
      end
      if (done_o) begin
        got = {first_angle_o, second_angle_o, third_angle_o, lock_state_o};
        if (angle_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %h", got);
        end else begin
          want = angle_queue.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: first %0d/%0d second %0d/%0d third %0d/%0d lock %0d/%0d",
                       want.first, got.first, want.second, got.second,
                       want.third, got.third, want.lock, got.lock);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("quaternion_to_euler_angles_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic quat_t random_quat();
    quat_t q;
    int a;
    case ($urandom_range(9))
      0, 1, 2: begin
        // Full 32-bit patterns, reaching every bit and the overflow extremes.
        q = {$urandom, $urandom, $urandom, $urandom};
      end
      3, 4: begin
        // Components near 2^30/sqrt(2), y of either sign: the lock test lands near 1.0 or near 0.
        a = A_UNIT + int'($urandom_range(4000)) - 2000;
        q.w = a;
        q.x = a + int'($urandom_range(200)) - 100;
        q.z = a + int'($urandom_range(200)) - 100;
        q.y = $urandom_range(1) ? -a : a;
      end
      default: begin
        // Components in the usual unit-quaternion range.
        q.w = int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        q.x = int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        q.y = int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        q.z = int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
      end
    endcase
    return q;
  endfunction

  // Waits until every sent word has come back, then for the pipeline to drain.
  // The queues are looked at on the falling edge, once the drivers have settled.
  task automatic drain();
    @(negedge clk_i);
    while (quat_queue.size() > 0 || angle_queue.size() > 0 || start)
      @(negedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_margin(logic [qte_pkg::MARGIN_W-1:0] m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    margin_model = m;
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) quat_queue.push_back(random_quat());
  endtask

  localparam int MAXP = 32'sh7FFF_FFFF;
  localparam int MAXN = 32'sh8000_0000;
  localparam int ONE  = 32'sh4000_0000;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: extremes, identity, both locks, the atan2 corner cases.
    quat_queue.push_back('{0, 0, 0, 0});
    quat_queue.push_back('{ONE, 0, 0, 0});
    quat_queue.push_back('{-ONE, 0, 0, 0});
    quat_queue.push_back('{0, ONE, 0, 0});
    quat_queue.push_back('{0, 0, ONE, 0});
    quat_queue.push_back('{0, 0, 0, ONE});
    quat_queue.push_back('{MAXP, MAXP, MAXP, MAXP});
    quat_queue.push_back('{MAXN, MAXN, MAXN, MAXN});
    quat_queue.push_back('{MAXP, MAXN, MAXN, MAXP});
    quat_queue.push_back('{MAXN, MAXP, MAXP, MAXN});
    quat_queue.push_back('{MAXP, MAXN, MAXP, MAXN});
    quat_queue.push_back('{A_UNIT, 0, -A_UNIT, 0});
    quat_queue.push_back('{A_UNIT, 0, A_UNIT, 0});
    quat_queue.push_back('{-A_UNIT, 0, A_UNIT, 0});
    quat_queue.push_back('{0, A_UNIT, 0, A_UNIT});
    quat_queue.push_back('{0, A_UNIT, 0, -A_UNIT});
    quat_queue.push_back('{-ONE, A_UNIT, 0, A_UNIT});
    quat_queue.push_back('{A_UNIT, A_UNIT, 0, 0});
    quat_queue.push_back('{0, 0, A_UNIT, A_UNIT});
    quat_queue.push_back('{-1, -1, -1, -1});
    drain();

    // Back-to-back words at the default margin, with one full pause in between.
    idle_pct = 0;
    random_words(80);
    drain();
    random_words(100);
    drain();

    // Zero margin: lock only strictly above one half; sender mostly idle.
    set_margin('0);
    idle_pct = 84;
    random_words(160);
    drain();

    // A margin of one half puts the threshold at zero.
    set_margin(30'd536870912);
    idle_pct = 0;
    random_words(150);
    drain();

    // Largest register value: the threshold is negative and every word locks.
    set_margin('1);
    idle_pct = 25;
    random_words(150);
    drain();

    // Random margins, mixed idling.
    for (int p = 0; p < 3; p++) begin
      set_margin(30'($urandom_range(536870912)));
      idle_pct = $urandom_range(1) ? 0 : 50;
      random_words(90);
      drain();
    end

    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("quaternion_to_euler_angles_tb OK");
    end else begin
      $display("quaternion_to_euler_angles_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_norm.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_angles.sv
sim/quaternion_to_euler_angles_tb.sv
